// ===== rtl/asq_pkg.sv =====
// Package for the array sequence table: defaults, request and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package asq_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        REQ_INSERT_AT     = 3'd0,
        REQ_INSERT_SORTED = 3'd1,
        REQ_ERASE         = 3'd2,
        REQ_REMOVE_ALL    = 3'd3,
        REQ_GET           = 3'd4,
        REQ_SET           = 3'd5,
        REQ_FIND          = 3'd6,
        REQ_NONE          = 3'd7
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_CNT, IDX_POS, IDX_INC, IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        K_HOLD, K_ZERO, K_CNT, K_POS, K_IDX, K_INC
    } k_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC, CNT_DEC, CNT_K
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_IDX, RD_IDX_DEC, RD_IDX_INC, RD_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_IDX, WA_K, WA_POS
    } wa_sel_t;

    typedef struct packed {
        logic         load;
        logic         status_set;
        status_code_t status_code;
        idx_op_t      idx_op;
        k_op_t        k_op;
        cnt_op_t      cnt_op;
        logic         rem_inc;
        logic         ridx_from_k;
        logic         ridx_from_idx;
        logic         rval_load;
        rd_sel_t      rd_sel;
        logic         wr_en;
        wa_sel_t      wa_sel;
        logic         wd_val;
        logic         out_load;
    } asq_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      full;
        logic      pos_gt;
        logic      pos_ge;
        logic      idx_at_cnt;
        logic      idx_at_k;
        logic      idx_last;
        logic      val_le;
        logic      val_eq;
        logic      out_free;
    } asq_stat_t;

endpackage

// ===== rtl/asq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/asq_ctrl.sv =====
// Sequencer for the array sequence table: steps each request through
// scan, shift, compact and access phases. Depends on asq_pkg.
module asq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  asq_pkg::asq_stat_t stat,
    output asq_pkg::asq_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DECIDE   = 14'b00000000000010,
        S_SCAN_RD  = 14'b00000000000100,
        S_SCAN_EX  = 14'b00000000001000,
        S_SHIFT_RD = 14'b00000000010000,
        S_SHIFT_WR = 14'b00000000100000,
        S_PUT      = 14'b00000001000000,
        S_ERASE_RD = 14'b00000010000000,
        S_ERASE_WR = 14'b00000100000000,
        S_REM_RD   = 14'b00001000000000,
        S_REM_EX   = 14'b00010000000000,
        S_GET_RD   = 14'b00100000000000,
        S_GET_EX   = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.status_code   = asq_pkg::ST_OK;
        cmd.idx_op        = asq_pkg::IDX_HOLD;
        cmd.k_op          = asq_pkg::K_HOLD;
        cmd.cnt_op        = asq_pkg::CNT_HOLD;
        cmd.rd_sel        = asq_pkg::RD_IDX;
        cmd.wa_sel        = asq_pkg::WA_IDX;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.kind)
                    asq_pkg::REQ_INSERT_AT:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (stat.pos_gt)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.k_op   = asq_pkg::K_POS;
                            cmd.idx_op = asq_pkg::IDX_CNT;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    asq_pkg::REQ_INSERT_SORTED:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.k_op   = asq_pkg::K_CNT;
                            cmd.idx_op = asq_pkg::IDX_ZERO;
                            state_next = S_SCAN_RD;
                        end
                    end
                    asq_pkg::REQ_FIND:
                    begin
                        cmd.idx_op = asq_pkg::IDX_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    asq_pkg::REQ_ERASE:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = asq_pkg::IDX_POS;
                            state_next = S_ERASE_RD;
                        end
                    end
                    asq_pkg::REQ_REMOVE_ALL:
                    begin
                        cmd.idx_op = asq_pkg::IDX_ZERO;
                        cmd.k_op   = asq_pkg::K_ZERO;
                        state_next = S_REM_RD;
                    end
                    asq_pkg::REQ_GET:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_GET_RD;
                        end
                    end
                    asq_pkg::REQ_SET:
                    begin
                        if (stat.pos_ge)
                        begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = asq_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = asq_pkg::WA_POS;
                            cmd.wd_val = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.idx_at_cnt)
                begin
                    if (stat.kind == asq_pkg::REQ_FIND)
                    begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = asq_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // no larger entry: k already holds the count
                        cmd.idx_op = asq_pkg::IDX_CNT;
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.rd_sel = asq_pkg::RD_IDX;
                    state_next = S_SCAN_EX;
                end
            end
            S_SCAN_EX:
            begin
                if (stat.kind == asq_pkg::REQ_FIND)
                begin
                    if (stat.val_eq)
                    begin
                        cmd.ridx_from_idx = 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_op = asq_pkg::IDX_INC;
                        state_next = S_SCAN_RD;
                    end
                end
                else if (stat.val_le)
                begin
                    cmd.k_op   = asq_pkg::K_IDX;
                    cmd.idx_op = asq_pkg::IDX_CNT;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd.idx_op = asq_pkg::IDX_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.idx_at_k)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.rd_sel = asq_pkg::RD_IDX_DEC;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = asq_pkg::WA_IDX;
                cmd.idx_op = asq_pkg::IDX_DEC;
                state_next = S_SHIFT_RD;
            end
            S_PUT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wa_sel      = asq_pkg::WA_K;
                cmd.wd_val      = 1'b1;
                cmd.cnt_op      = asq_pkg::CNT_INC;
                cmd.ridx_from_k = 1'b1;
                state_next      = S_DONE;
            end
            S_ERASE_RD:
            begin
                if (stat.idx_last)
                begin
                    cmd.cnt_op = asq_pkg::CNT_DEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = asq_pkg::RD_IDX_INC;
                    state_next = S_ERASE_WR;
                end
            end
            S_ERASE_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = asq_pkg::WA_IDX;
                cmd.idx_op = asq_pkg::IDX_INC;
                state_next = S_ERASE_RD;
            end
            S_REM_RD:
            begin
                if (stat.idx_at_cnt)
                begin
                    cmd.cnt_op = asq_pkg::CNT_K;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = asq_pkg::RD_IDX;
                    state_next = S_REM_EX;
                end
            end
            S_REM_EX:
            begin
                if (stat.val_eq)
                begin
                    cmd.rem_inc = 1'b1;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = asq_pkg::WA_K;
                    cmd.k_op   = asq_pkg::K_INC;
                end
                cmd.idx_op = asq_pkg::IDX_INC;
                state_next = S_REM_RD;
            end
            S_GET_RD:
            begin
                cmd.rd_sel = asq_pkg::RD_POS;
                state_next = S_GET_EX;
            end
            S_GET_EX:
            begin
                cmd.rval_load = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/asq_dp.sv =====
// Datapath for the array sequence table: entry RAM, pointers, count,
// result fields and the output register. Depends on asq_pkg, asq_ram.
module asq_dp #(
    parameter int DEPTH       = asq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = asq_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [47:0]        in_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [63:0]        out_data,
    input  asq_pkg::asq_cmd_t  cmd,
    output asq_pkg::asq_stat_t stat
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > 9) ? CW : 9;

    asq_pkg::req_kind_t      kind_reg;
    logic [8:0]              pos_reg;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           k_reg;
    logic [CW-1:0]           rem_reg;
    asq_pkg::status_code_t   status_reg;
    logic [CW-1:0]           ridx_reg;
    logic [VALUE_WIDTH-1:0]  rval_reg;
    logic                    out_valid_reg;
    logic [63:0]             out_data_reg;

    logic [CMPW-1:0]         pos_w;
    logic [CMPW-1:0]         cnt_w;
    logic [CW-1:0]           idx_dec;
    logic [CW:0]             idx_inc;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic [VALUE_WIDTH-1:0]  wdata;
    logic [VALUE_WIDTH-1:0]  rdata;
    logic [31:0]             in_value;

    // the 32-bit field is taken as raw bits and fitted to the entry width
    assign in_value = in_data[43:12];
    assign pos_w    = CMPW'(pos_reg);
    assign cnt_w    = CMPW'(cnt_reg);
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_inc  = (CW + 1)'(idx_reg) + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            asq_pkg::RD_IDX:     raddr = idx_reg[AW-1:0];
            asq_pkg::RD_IDX_DEC: raddr = idx_dec[AW-1:0];
            asq_pkg::RD_IDX_INC: raddr = idx_inc[AW-1:0];
            asq_pkg::RD_POS:     raddr = pos_w[AW-1:0];
            default:             raddr = idx_reg[AW-1:0];
        endcase
        case (cmd.wa_sel)
            asq_pkg::WA_IDX: waddr = idx_reg[AW-1:0];
            asq_pkg::WA_K:   waddr = k_reg[AW-1:0];
            asq_pkg::WA_POS: waddr = pos_w[AW-1:0];
            default:         waddr = idx_reg[AW-1:0];
        endcase
        wdata = cmd.wd_val ? val_reg : rdata;
    end

    asq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.full       = (CMPW'(cnt_reg) >= CMPW'(DEPTH));
        stat.pos_gt     = (pos_w > cnt_w);
        stat.pos_ge     = (pos_w >= cnt_w);
        stat.idx_at_cnt = (idx_reg == cnt_reg);
        stat.idx_at_k   = (idx_reg == k_reg);
        stat.idx_last   = (idx_inc == (CW + 1)'(cnt_reg));
        stat.val_le     = ($signed(val_reg) <= $signed(rdata));
        stat.val_eq     = (val_reg == rdata);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.cnt_op)
                asq_pkg::CNT_INC: cnt_reg <= cnt_reg + 1'b1;
                asq_pkg::CNT_DEC: cnt_reg <= cnt_reg - 1'b1;
                asq_pkg::CNT_K:   cnt_reg <= k_reg;
                default:          cnt_reg <= cnt_reg;
            endcase
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= asq_pkg::req_kind_t'(in_data[2:0]);
            pos_reg    <= in_data[11:3];
            val_reg    <= VALUE_WIDTH'(in_value);
            status_reg <= asq_pkg::ST_OK;
            ridx_reg   <= '0;
            rval_reg   <= '0;
            rem_reg    <= '0;
        end
        if (cmd.status_set)
        begin
            status_reg <= cmd.status_code;
        end
        case (cmd.idx_op)
            asq_pkg::IDX_ZERO: idx_reg <= '0;
            asq_pkg::IDX_CNT:  idx_reg <= cnt_reg;
            asq_pkg::IDX_POS:  idx_reg <= pos_w[CW-1:0];
            asq_pkg::IDX_INC:  idx_reg <= idx_inc[CW-1:0];
            asq_pkg::IDX_DEC:  idx_reg <= idx_dec;
            default:           idx_reg <= idx_reg;
        endcase
        case (cmd.k_op)
            asq_pkg::K_ZERO: k_reg <= '0;
            asq_pkg::K_CNT:  k_reg <= cnt_reg;
            asq_pkg::K_POS:  k_reg <= pos_w[CW-1:0];
            asq_pkg::K_IDX:  k_reg <= idx_reg;
            asq_pkg::K_INC:  k_reg <= k_reg + 1'b1;
            default:         k_reg <= k_reg;
        endcase
        if (cmd.rem_inc)
        begin
            rem_reg <= rem_reg + 1'b1;
        end
        if (cmd.ridx_from_k)
        begin
            ridx_reg <= k_reg;
        end
        else if (cmd.ridx_from_idx)
        begin
            ridx_reg <= idx_reg;
        end
        if (cmd.rval_load)
        begin
            rval_reg <= rdata;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {2'b00,
                             (cnt_reg == '0),
                             9'(cnt_reg),
                             9'(rem_reg),
                             32'(signed'(rval_reg)),
                             9'(ridx_reg),
                             status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/array_sequence_table.sv =====
// Top level of the array sequence table: bounded ordered list of signed values.
// Depends on asq_pkg, asq_ctrl, asq_dp (which holds asq_ram).
//
//  Channel  | Direction | Group                | Content
//  ---------+-----------+----------------------+------------------------------
//  request  | in        | s_axis_t*            | one request per transaction
//  result   | out       | m_axis_t*            | one result per request
//
// Each request is decoded and then walks the entry RAM, which has one read and
// one write port with registered read; each element step is a read state
// followed by a write or compare state. Position and full errors go from the
// decode state straight to the result stage.
// Reset: asynchronous, clears the count, the output valid flag and the sequencer; entries need none.
// Stalls: the result waits in an output register; the next request is taken
// while it waits, and only its own completion holds for the register to free.
module array_sequence_table #(
    parameter int DEPTH       = asq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = asq_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[2:0], position[11:3], item_value[43:12], zero[47:44]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], result_index[10:2], read_value[42:11],
    // removed_count[51:43], item_count[60:52], is_empty[61], zero[63:62]
    output logic [63:0] m_axis_tdata
);

    asq_pkg::asq_cmd_t  cmd;
    asq_pkg::asq_stat_t stat;

    // sequencer: decides each step of a request
    asq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, pointers and result register
    asq_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== dv/tb_array_sequence_table.sv =====
// Self-checking testbench for array_sequence_table: drives request transactions,
// predicts each result with a behavioral list model and checks every field.
// Depends on asq_pkg and the array_sequence_table RTL.
`timescale 1ns / 100ps

module tb_array_sequence_table;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    // laid out to match the result tdata, first field in the highest bits
    typedef struct packed {
        logic        is_empty;
        logic [8:0]  item_count;
        logic [8:0]  removed_count;
        logic [31:0] read_value;
        logic [8:0]  result_index;
        logic [1:0]  status;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    array_sequence_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the list contents and length
    logic signed [31:0] shadow_list [DEPTH];
    int                 shadow_len;

    logic [47:0]   request_queue [$];
    table_result_t expected_results [$];

    int  error_count;
    int  results_seen;
    int  idle_cycles;
    int  kind_hits [8];
    int  status_hits [4];
    bit  stimulus_done;
    bit  sender_calm;
    bit  receiver_calm;
    bit  long_holdoff;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [47:0] pack_request(asq_pkg::req_kind_t kind, int pos,
                                                  logic [31:0] value);
        logic [47:0] word;
        word = '0;
        word[2:0]   = kind;
        word[11:3]  = pos[8:0];
        word[43:12] = value;
        return word;
    endfunction

    // Apply one request to the shadow list and return the result it should produce
    function automatic table_result_t predict_list_result(logic [47:0] word);
        table_result_t       res;
        asq_pkg::req_kind_t  kind;
        int                  pos;
        logic signed [31:0]  value;
        int                  slot;
        int                  kept;
        kind  = asq_pkg::req_kind_t'(word[2:0]);
        pos   = word[11:3];
        value = word[43:12];
        res   = '0;
        case (kind)
            asq_pkg::REQ_INSERT_AT, asq_pkg::REQ_INSERT_SORTED:
            begin
                if (shadow_len >= DEPTH)
                    res.status = asq_pkg::ST_FULL;
                else if (kind == asq_pkg::REQ_INSERT_AT && pos > shadow_len)
                    res.status = asq_pkg::ST_BAD_POS;
                else
                begin
                    slot = pos;
                    if (kind == asq_pkg::REQ_INSERT_SORTED)
                    begin
                        slot = shadow_len;
                        for (int i = shadow_len - 1; i >= 0; i--)
                            if (value <= shadow_list[i])
                                slot = i;
                    end
                    for (int i = shadow_len; i > slot; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[slot] = value;
                    shadow_len++;
                    res.result_index = slot[8:0];
                end
            end
            asq_pkg::REQ_ERASE:
            begin
                if (pos >= shadow_len)
                    res.status = asq_pkg::ST_BAD_POS;
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            asq_pkg::REQ_REMOVE_ALL:
            begin
                kept = 0;
                for (int i = 0; i < shadow_len; i++)
                    if (shadow_list[i] == value)
                        res.removed_count++;
                    else
                    begin
                        shadow_list[kept] = shadow_list[i];
                        kept++;
                    end
                shadow_len = kept;
            end
            asq_pkg::REQ_GET:
            begin
                if (pos >= shadow_len)
                    res.status = asq_pkg::ST_BAD_POS;
                else
                    res.read_value = shadow_list[pos];
            end
            asq_pkg::REQ_SET:
            begin
                if (pos >= shadow_len)
                    res.status = asq_pkg::ST_BAD_POS;
                else
                    shadow_list[pos] = value;
            end
            asq_pkg::REQ_FIND:
            begin
                res.status = asq_pkg::ST_NOT_FOUND;
                for (int i = shadow_len - 1; i >= 0; i--)
                    if (shadow_list[i] == value)
                    begin
                        res.status       = asq_pkg::ST_OK;
                        res.result_index = i[8:0];
                    end
            end
            default: ;
        endcase
        res.item_count = shadow_len[8:0];
        res.is_empty   = (shadow_len == 0);
        return res;
    endfunction

    // Enqueue a request and its prediction together
    task automatic post_request(asq_pkg::req_kind_t kind, int pos, logic [31:0] value);
        logic [47:0] word;
        word = pack_request(kind, pos, value);
        request_queue.push_back(word);
        expected_results.push_back(predict_list_result(word));
        kind_hits[kind]++;
    endtask

    // Values drawn mostly from a small pool so that remove, find and sorted ties hit
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(0, 7) - 4;
        else if (sel == 6)
            return 32'h8000_0000;
        else if (sel == 7)
            return 32'h7fff_ffff;
        return $urandom;
    endfunction

    // Stimulus: directed corners first, then random traffic with a fill phase
    initial
    begin
        int          pos;
        int          kind_sel;
        logic [31:0] value;
        shadow_len    = 0;
        error_count   = 0;
        stimulus_done = 0;
        for (int i = 0; i < 8; i++)
            kind_hits[i] = 0;

        // Errors on an empty table, then extremes of value and position
        post_request(asq_pkg::REQ_GET, 0, 32'h0);
        post_request(asq_pkg::REQ_ERASE, 0, 32'h0);
        post_request(asq_pkg::REQ_SET, 0, 32'h1);
        post_request(asq_pkg::REQ_FIND, 0, 32'h5);
        post_request(asq_pkg::REQ_REMOVE_ALL, 0, 32'h5);
        post_request(asq_pkg::REQ_INSERT_AT, 1, 32'h1);
        post_request(asq_pkg::REQ_INSERT_AT, 0, 32'h7fff_ffff);
        post_request(asq_pkg::REQ_INSERT_SORTED, 0, 32'h8000_0000);
        post_request(asq_pkg::REQ_INSERT_SORTED, 0, 32'h0);
        post_request(asq_pkg::REQ_INSERT_SORTED, 0, 32'h0);
        post_request(asq_pkg::REQ_INSERT_AT, 511, 32'hffff_ffff);
        post_request(asq_pkg::REQ_GET, 511, 32'hffff_ffff);
        post_request(asq_pkg::REQ_GET, 0, 32'h0);
        post_request(asq_pkg::REQ_SET, 4, 32'h7fff_ffff);
        post_request(asq_pkg::REQ_FIND, 0, 32'h7fff_ffff);
        post_request(asq_pkg::REQ_REMOVE_ALL, 0, 32'h0);
        post_request(asq_pkg::REQ_ERASE, 1, 32'h0);
        post_request(asq_pkg::REQ_NONE, 511, 32'hffff_ffff);
        post_request(asq_pkg::REQ_FIND, 0, 32'h1234_5678);
        post_request(asq_pkg::REQ_REMOVE_ALL, 0, 32'h5);

        // Fill the table to the top, hit full on both inserts, then drain half
        while (shadow_len < DEPTH)
            post_request(asq_pkg::REQ_INSERT_AT, $urandom_range(0, shadow_len), $urandom);
        post_request(asq_pkg::REQ_INSERT_AT, 0, 32'h1);
        post_request(asq_pkg::REQ_INSERT_SORTED, 0, 32'h1);
        post_request(asq_pkg::REQ_GET, DEPTH - 1, 32'h0);
        post_request(asq_pkg::REQ_ERASE, DEPTH - 1, 32'h0);
        while (shadow_len > DEPTH / 2)
            post_request(asq_pkg::REQ_ERASE, $urandom_range(0, shadow_len - 1), $urandom);

        // Random mix, insert-biased so the list grows and shrinks
        for (int n = 0; n < 240; n++)
        begin
            kind_sel = $urandom_range(0, 99);
            value    = pick_value();
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 511);
            else
                pos = $urandom_range(0, shadow_len);
            if (kind_sel < 22)
                post_request(asq_pkg::REQ_INSERT_AT, pos, value);
            else if (kind_sel < 44)
                post_request(asq_pkg::REQ_INSERT_SORTED, $urandom_range(0, 511), value);
            else if (kind_sel < 56)
                post_request(asq_pkg::REQ_ERASE, pos, value);
            else if (kind_sel < 62)
                post_request(asq_pkg::REQ_REMOVE_ALL, pos, value);
            else if (kind_sel < 75)
                post_request(asq_pkg::REQ_GET, pos, value);
            else if (kind_sel < 85)
                post_request(asq_pkg::REQ_SET, pos, value);
            else if (kind_sel < 98)
                post_request(asq_pkg::REQ_FIND, pos, value);
            else
                post_request(asq_pkg::REQ_NONE, pos, value);
        end
        stimulus_done = 1;
    end

    // Reset: asserted at the start, released once
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idle modes: calm stretch early on, random gaps elsewhere
    always @(posedge clk)
    begin
        sender_calm   <= (results_seen > 40 && results_seen < 140);
        receiver_calm <= (results_seen > 60 && results_seen < 160);
    end

    // Driver: present the head of the request queue, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(request_queue.pop_front());
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                // Offer the next transaction unless an idle gap is drawn
                if (request_queue.size() > 0 &&
                    (sender_calm || $urandom_range(0, 99) >= 10))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= request_queue[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure, including one long hold-off to fill the block
    initial
    begin
        m_axis_tready = 1'b0;
        long_holdoff  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results_seen == 200 && !long_holdoff)
            begin
                long_holdoff = 1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_axis_tready <= receiver_calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // Monitor: compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[61:0];
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count <= error_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (got !== want)
                begin
                    $display("%0t: mismatch expected st=%0d idx=%0d val=%h rem=%0d cnt=%0d e=%0b",
                             $time, want.status, want.result_index, want.read_value,
                             want.removed_count, want.item_count, want.is_empty);
                    $display("%0t:            actual st=%0d idx=%0d val=%h rem=%0d cnt=%0d e=%0b",
                             $time, got.status, got.result_index, got.read_value,
                             got.removed_count, got.item_count, got.is_empty);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial
    begin
        results_seen = 0;
        for (int i = 0; i < 4; i++)
            status_hits[i] = 0;
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(stimulus_done && request_queue.size() == 0 &&
                 expected_results.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            // Drain window for any stray result
            repeat (1200) @(posedge clk);
            $display("Covered %0d requests: ins_at %0d sorted %0d erase %0d remove %0d",
                     results_seen, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
            $display("get %0d set %0d find %0d unused %0d; ok/full/pos/miss %0d/%0d/%0d/%0d",
                     kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7],
                     status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
            if (error_count == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
